@@ rtl/tlla_pkg.sv @@
package tlla_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_NEIGHBOURHOOD   = 3'd0;
  localparam logic [2:0] REG_RULE_SELECT     = 3'd1;
  localparam logic [2:0] REG_MAX_GENERATIONS = 3'd2;
  localparam logic [2:0] REG_HISTORY_DEPTH   = 3'd3;
  localparam logic [2:0] REG_COLS_IN_USE     = 3'd4;
  localparam logic [2:0] REG_ROWS_IN_USE     = 3'd5;

  // Neighbourhood codes.
  localparam logic NBH_MOORE       = 1'b0;
  localparam logic NBH_VON_NEUMANN = 1'b1;

  // Birth/survive rule codes.
  localparam logic [2:0] RULE_B3_S1234     = 3'd0;
  localparam logic [2:0] RULE_B3_S12345    = 3'd1;
  localparam logic [2:0] RULE_B4678_S35678 = 3'd2;
  localparam logic [2:0] RULE_B5678_S45678 = 3'd3;
  localparam logic [2:0] RULE_B2_S123      = 3'd4;

  typedef logic [3:0] nbr_count_t;

  function automatic logic next_cell(input logic [2:0] rule, input nbr_count_t n,
                                     input logic wall);
    logic res;
    begin
      case (rule)
        RULE_B3_S1234:     res = wall ? (n >= 4'd1 && n <= 4'd4) : (n == 4'd3);
        RULE_B3_S12345:    res = wall ? (n >= 4'd1 && n <= 4'd5) : (n == 4'd3);
        RULE_B4678_S35678: res = wall ? (n == 4'd3 || n >= 4'd5) : (n == 4'd4 || n >= 4'd6);
        RULE_B5678_S45678: res = wall ? (n >= 4'd4) : (n >= 4'd5);
        RULE_B2_S123:      res = wall ? (n >= 4'd1 && n <= 4'd3) : (n == 4'd2);
        default:           res = 1'b0;
      endcase
      return res;
    end
  endfunction

endpackage

@@ rtl/tlla_ram.sv @@
module tlla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/toroidal_life_like_automaton.sv @@
// Channel  Direction  Handshake                  Payload
// in       input      in_valid / in_ready        in_row_cells, in_final_row
// out      output     out_valid / out_ready      out_row_index, out_cells, out_last_of_grid,
//                                                out_generations_run, out_settled
// cfg      input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Each accepted row is written to the work memory. A final row starts a run: the loaded grid
// is copied row by row into the history memory, then per generation each row reads its five
// source rows and then the grids held, bounded by the single read port of the history memory.
// The result rows then leave one by one, each held until out_ready.
// Reset is synchronous and active low; the memories are not cleared.
// in_ready is low from the final row until the last result transaction.
module toroidal_life_like_automaton
  import tlla_pkg::*;
#(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 32,
  parameter int HISTORY  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_row_cells,
  input  logic        in_final_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_row_index,
  output logic [31:0] out_cells,
  output logic        out_last_of_grid,
  output logic [9:0]  out_generations_run,
  output logic        out_settled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int GW    = MAX_COLS;
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int SLOTS = HISTORY + 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int HD    = SLOTS * MAX_ROWS;
  localparam int HAW   = $clog2(HD);
  localparam int HCW   = $clog2(HISTORY + 1);
  localparam int STW   = $clog2(HISTORY + 7);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_COPY     = 4'd1;
  localparam logic [3:0] S_COPY_WR  = 4'd2;
  localparam logic [3:0] S_GEN_CHK  = 4'd3;
  localparam logic [3:0] S_ROW      = 4'd4;
  localparam logic [3:0] S_GEN_END  = 4'd5;
  localparam logic [3:0] S_OUT_RD   = 4'd6;
  localparam logic [3:0] S_OUT_LD   = 4'd7;
  localparam logic [3:0] S_OUT_WAIT = 4'd8;

  typedef logic [GW-1:0] grid_row_t;

  logic           nbh_r;
  logic [2:0]     rule_r;
  logic [9:0]     max_gen_r;
  logic [2:0]     depth_cfg_r;
  logic [5:0]     cols_r;
  logic [5:0]     rows_r;

  logic [3:0]     state_r;
  logic [RW-1:0]  load_ptr_r;
  logic [RW-1:0]  row_r;
  logic [STW-1:0] step_r;
  logic [SW-1:0]  newest_r;
  logic [HCW-1:0] hcount_r;
  logic [9:0]     gen_r;
  logic           settled_r;
  logic [HISTORY-1:0] match_r;
  grid_row_t      win_r [5];
  grid_row_t      fresh_r;

  logic           out_valid_r;
  logic [4:0]     out_row_r;
  logic [31:0]    out_cells_r;
  logic           out_last_r;

  logic [NCW-1:0] nc;
  logic [NRW-1:0] nr;
  logic [HCW-1:0] depth;
  grid_row_t      col_mask;
  grid_row_t      fresh_nxt;

  logic           w_we;
  logic [RW-1:0]  w_waddr;
  grid_row_t      w_wdata;
  grid_row_t      w_rdata;
  logic           h_we;
  logic [HAW-1:0] h_waddr;
  grid_row_t      h_wdata;
  logic [HAW-1:0] h_raddr;
  grid_row_t      h_rdata;

  logic [NRW+1:0] nb_t;
  logic [RW-1:0]  nb_row;
  logic [SW:0]    cmp_t;
  logic [SW-1:0]  cmp_slot;
  logic [SW-1:0]  new_slot;
  logic           row_last;
  logic [STW-1:0] step_end;
  logic           in_acc;
  logic [HISTORY-1:0] live_k;

  function automatic logic [HAW-1:0] haddr(input logic [SW-1:0] slot,
                                           input logic [RW-1:0] row);
    return HAW'(HAW'(slot) * HAW'(MAX_ROWS)) + HAW'(row);
  endfunction

  // Clamped geometry and depth.
  always_comb begin
    if (cols_r < 6'd3) begin
      nc = NCW'(3);
    end else if (32'(cols_r) > 32'(MAX_COLS)) begin
      nc = NCW'(MAX_COLS);
    end else begin
      nc = NCW'(cols_r);
    end
    if (rows_r < 6'd3) begin
      nr = NRW'(3);
    end else if (32'(rows_r) > 32'(MAX_ROWS)) begin
      nr = NRW'(MAX_ROWS);
    end else begin
      nr = NRW'(rows_r);
    end
    if (depth_cfg_r == 3'd0) begin
      depth = HCW'(1);
    end else if (32'(depth_cfg_r) > 32'(HISTORY)) begin
      depth = HCW'(HISTORY);
    end else begin
      depth = HCW'(depth_cfg_r);
    end
  end

  // One new row from the five buffered rows r-2 .. r+2.
  always_comb begin
    int ncv, cm1, cm2, cp1, cp2;
    nbr_count_t n;
    ncv = int'(nc);
    fresh_nxt = '0;
    col_mask = '0;
    for (int c = 0; c < GW; c++) begin
      cm1 = (c == 0) ? ncv - 1 : c - 1;
      cm2 = (c >= 2) ? c - 2 : c + ncv - 2;
      cp1 = (c + 1 >= ncv) ? c + 1 - ncv : c + 1;
      cp2 = (c + 2 >= ncv) ? c + 2 - ncv : c + 2;
      if (nbh_r == NBH_MOORE) begin
        n = 4'(win_r[1][cm1]) + 4'(win_r[1][c]) + 4'(win_r[1][cp1])
          + 4'(win_r[2][cm1]) + 4'(win_r[2][cp1])
          + 4'(win_r[3][cm1]) + 4'(win_r[3][c]) + 4'(win_r[3][cp1]);
      end else begin
        n = 4'(win_r[0][c]) + 4'(win_r[1][c]) + 4'(win_r[3][c]) + 4'(win_r[4][c])
          + 4'(win_r[2][cm2]) + 4'(win_r[2][cm1])
          + 4'(win_r[2][cp1]) + 4'(win_r[2][cp2]);
      end
      col_mask[c] = (c < ncv);
      fresh_nxt[c] = (c < ncv) && next_cell(rule_r, n, win_r[2][c]);
    end
  end

  // Address helpers.
  always_comb begin
    nb_t = (NRW+2)'(row_r) + (NRW+2)'(nr) + (NRW+2)'(step_r) - (NRW+2)'(2);
    if (nb_t >= (NRW+2)'(nr)) nb_t = nb_t - (NRW+2)'(nr);
    if (nb_t >= (NRW+2)'(nr)) nb_t = nb_t - (NRW+2)'(nr);
    nb_row = RW'(nb_t);
    cmp_t = (SW+1)'(newest_r) + (SW+1)'(SLOTS) - (SW+1)'(step_r - STW'(6));
    if (cmp_t >= (SW+1)'(SLOTS)) cmp_t = cmp_t - (SW+1)'(SLOTS);
    cmp_slot = SW'(cmp_t);
    new_slot = (32'(newest_r) == SLOTS - 1) ? '0 : newest_r + SW'(1);
    row_last = ((NRW+1)'(row_r) + (NRW+1)'(1) == (NRW+1)'(nr));
    step_end = STW'(6) + STW'(hcount_r);
    for (int k = 0; k < HISTORY; k++) begin
      live_k[k] = (k < int'(hcount_r));
    end
  end

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Memory port steering.
  always_comb begin
    w_we    = 1'b0;
    w_waddr = load_ptr_r;
    w_wdata = GW'(in_row_cells);
    h_we    = 1'b0;
    h_waddr = haddr('0, row_r);
    h_wdata = w_rdata & col_mask;
    h_raddr = haddr(newest_r, row_r);
    if (in_acc) begin
      w_we = 1'b1;
    end
    unique case (state_r)
      S_COPY_WR: begin
        h_we = 1'b1;
      end
      S_ROW: begin
        if (step_r < STW'(5)) begin
          h_raddr = haddr(newest_r, nb_row);
        end else begin
          h_raddr = haddr(cmp_slot, row_r);
        end
        if (step_r == step_end) begin
          h_we    = 1'b1;
          h_waddr = haddr(new_slot, row_r);
          h_wdata = fresh_r;
        end
      end
      S_OUT_LD: begin
        w_we    = 1'b1;
        w_waddr = row_r;
        w_wdata = h_rdata;
      end
      default: begin
      end
    endcase
  end

  tlla_ram #(.WIDTH(GW), .DEPTH(MAX_ROWS)) u_work_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (row_r),
    .rdata (w_rdata)
  );

  // One slot more than HISTORY, so a new grid never lands on the grid being read
  // or on any grid it is compared against.
  tlla_ram #(.WIDTH(GW), .DEPTH(HD)) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbh_r       <= NBH_MOORE;
      rule_r      <= RULE_B3_S1234;
      max_gen_r   <= 10'd16;
      depth_cfg_r <= 3'd2;
      cols_r      <= 6'd32;
      rows_r      <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NEIGHBOURHOOD:   nbh_r       <= cfg_data[0];
        REG_RULE_SELECT:     rule_r      <= cfg_data[2:0];
        REG_MAX_GENERATIONS: max_gen_r   <= cfg_data[9:0];
        REG_HISTORY_DEPTH:   depth_cfg_r <= cfg_data[2:0];
        REG_COLS_IN_USE:     cols_r      <= cfg_data[5:0];
        REG_ROWS_IN_USE:     rows_r      <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_ptr_r  <= '0;
      row_r       <= '0;
      step_r      <= '0;
      newest_r    <= '0;
      hcount_r    <= '0;
      gen_r       <= '0;
      settled_r   <= 1'b0;
      match_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_final_row) begin
              load_ptr_r <= '0;
              row_r      <= '0;
              newest_r   <= '0;
              hcount_r   <= HCW'(1);
              gen_r      <= '0;
              settled_r  <= 1'b0;
              state_r    <= S_COPY;
            end else if (32'(load_ptr_r) == MAX_ROWS - 1) begin
              load_ptr_r <= '0;
            end else begin
              load_ptr_r <= load_ptr_r + RW'(1);
            end
          end
        end
        S_COPY: begin
          state_r <= S_COPY_WR;
        end
        S_COPY_WR: begin
          if (row_last) begin
            state_r <= S_GEN_CHK;
          end else begin
            row_r   <= row_r + RW'(1);
            state_r <= S_COPY;
          end
        end
        S_GEN_CHK: begin
          row_r   <= '0;
          step_r  <= '0;
          match_r <= '1;
          if (gen_r < max_gen_r && !settled_r) begin
            state_r <= S_ROW;
          end else begin
            state_r <= S_OUT_RD;
          end
        end
        S_ROW: begin
          for (int j = 0; j < 5; j++) begin
            if (step_r == STW'(j + 1)) begin
              win_r[j] <= h_rdata;
            end
          end
          if (step_r == STW'(6)) begin
            fresh_r <= fresh_nxt;
          end
          for (int k = 0; k < HISTORY; k++) begin
            if (step_r == STW'(k + 7)) begin
              match_r[k] <= match_r[k] && (h_rdata == fresh_r);
            end
          end
          if (step_r == step_end) begin
            step_r <= '0;
            if (row_last) begin
              state_r <= S_GEN_END;
            end else begin
              row_r <= row_r + RW'(1);
            end
          end else begin
            step_r <= step_r + STW'(1);
          end
        end
        S_GEN_END: begin
          settled_r <= |(match_r & live_k);
          newest_r  <= new_slot;
          if (hcount_r < depth) begin
            hcount_r <= hcount_r + HCW'(1);
          end else begin
            hcount_r <= depth;
          end
          gen_r   <= gen_r + 10'd1;
          state_r <= S_GEN_CHK;
        end
        S_OUT_RD: begin
          state_r <= S_OUT_LD;
        end
        S_OUT_LD: begin
          out_valid_r <= 1'b1;
          out_row_r   <= 5'(row_r);
          out_cells_r <= 32'(h_rdata);
          out_last_r  <= row_last;
          state_r     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              row_r   <= row_r + RW'(1);
              state_r <= S_OUT_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_row_index       = out_row_r;
  assign out_cells           = out_cells_r;
  assign out_last_of_grid    = out_last_r;
  assign out_generations_run = gen_r;
  assign out_settled         = settled_r;

`ifndef SYNTHESIS
  a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT_WAIT) else $error("result held outside output wait");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while a result is pending");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROW |-> hcount_r != '0 && 32'(hcount_r) <= HISTORY)
    else $error("history count out of range during a generation");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROW |-> step_r <= step_end) else $error("row sequencer overran");
`endif

endmodule
